### rtl/mgd_pkg.sv
// shared types and constants for the masked grid diffusion step core
package mgd_pkg;

	// item kinds on the input channel
	localparam logic ACT_CELL  = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	// class code of a fluid cell; every other code passes through
	localparam logic [1:0] CLS_FLUID = 2'd0;

	// configuration register indexes
	typedef logic [3:0] cfg_idx_t;
	localparam cfg_idx_t REG_GRID_WIDTH  = 4'd0;
	localparam cfg_idx_t REG_GRID_HEIGHT = 4'd1;
	localparam cfg_idx_t REG_COEF_X      = 4'd2;
	localparam cfg_idx_t REG_COEF_Y      = 4'd3;

	// configuration data is as wide as the widest register
	localparam int CFG_DATA_W = 16;

	// height clamp and reset geometry
	localparam int MAX_HEIGHT     = 4096;
	localparam int RESET_WIDTH    = 64;
	localparam int RESET_HEIGHT   = 64;

	// result queue depth, a power of two
	localparam int FIFO_DEPTH = 8;

	typedef struct packed {
		logic               action;
		logic signed [31:0] cell_value;
		logic [1:0]         cell_class;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] new_value;
		logic               last_cell;
	} out_item_t;

	// one line buffer entry
	typedef struct packed {
		logic [1:0]         cls;
		logic signed [31:0] val;
	} cell_t;

	// control travelling with the line buffer read data
	typedef struct packed {
		logic  valid;
		logic  res;
		logic  has_left;
		logic  has_right;
		logic  has_down;
		logic  has_up;
		logic  last_cell;
		cell_t up;
	} stage_ctl_t;

endpackage

### rtl/masked_grid_diffusion_step_core.sv
// top level: configuration, raster counters, line buffer control and result credit
//
//  channel | direction | handshake            | payload
//  in      | into core | in_valid / in_ready   | in_data  (action, cell_value, cell_class)
//  out     | from core | out_valid / out_ready | out_data (new_value, last_cell)
//  cfg     | into core | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per clock while in_ready is high; results pass stages s1 to s4 and the queue
// the line buffer reads the right and down neighbors and writes the new cell in the same cycle
// after reset the line buffers hold nothing valid; no clearing pass, the first row fills them
// up to eight results may be owed; in_ready drops only while all eight are still untaken
// cfg_ready is always high
module masked_grid_diffusion_step_core #(
	parameter int MAX_WIDTH = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  mgd_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output mgd_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  mgd_pkg::cfg_idx_t               cfg_index,
	input  logic [mgd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);       // column index
	localparam int WW  = CW + 1;                   // width value
	localparam int AW  = CW + 1;                   // buffer address: row parity and column
	localparam int EW  = (WW > 11) ? WW : 11;      // width clamp compare
	localparam int HW  = 13;
	localparam int CRW = $clog2(mgd_pkg::FIFO_DEPTH + 1);
	localparam int RESET_W = (mgd_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
	                                                           : mgd_pkg::RESET_WIDTH;

	logic [WW-1:0]  eff_w_q;
	logic [HW-1:0]  eff_h_q;
	logic [15:0]    coef_x_q, coef_y_q;
	logic [CW-1:0]  col_q;
	logic [HW-1:0]  row_q;
	logic [CRW-1:0] credit_q;

	logic           cfg_wr, geom_wr;
	logic [EW-1:0]  gw_ext, gw_clamp;
	logic [HW-1:0]  gh, gh_clamp;

	logic           in_acc, is_cell, rows_open, active, res_acc, last;
	logic [WW-1:0]  col_next;
	logic           out_pop, we, fwd_a;
	logic [AW-1:0]  waddr, raddr_a;
	mgd_pkg::cell_t wcell, rd_a, rd_b;

	mgd_pkg::stage_ctl_t ctl_s1;
	logic                push;
	mgd_pkg::out_item_t  push_data;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign geom_wr   = cfg_wr && (cfg_index == mgd_pkg::REG_GRID_WIDTH ||
	                              cfg_index == mgd_pkg::REG_GRID_HEIGHT);

	// width and height clamped once, when written
	always_comb begin
		gw_ext = EW'(cfg_data[10:0]);
		if (gw_ext == '0) begin
			gw_clamp = EW'(1);
		end else if (gw_ext > EW'(MAX_WIDTH)) begin
			gw_clamp = EW'(MAX_WIDTH);
		end else begin
			gw_clamp = gw_ext;
		end
		gh = cfg_data[HW-1:0];
		if (gh == '0) begin
			gh_clamp = HW'(1);
		end else if (gh > HW'(mgd_pkg::MAX_HEIGHT)) begin
			gh_clamp = HW'(mgd_pkg::MAX_HEIGHT);
		end else begin
			gh_clamp = gh;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q  <= WW'(RESET_W);
			eff_h_q  <= HW'(mgd_pkg::RESET_HEIGHT);
			coef_x_q <= '0;
			coef_y_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				mgd_pkg::REG_GRID_WIDTH:  eff_w_q  <= gw_clamp[WW-1:0];
				mgd_pkg::REG_GRID_HEIGHT: eff_h_q  <= gh_clamp;
				mgd_pkg::REG_COEF_X:      coef_x_q <= cfg_data;
				mgd_pkg::REG_COEF_Y:      coef_y_q <= cfg_data;
				default:                  eff_w_q  <= eff_w_q;
			endcase
		end
	end

	// input decode: cells while rows remain, flushes once the grid is in
	assign in_ready  = credit_q < CRW'(mgd_pkg::FIFO_DEPTH);
	assign in_acc    = in_valid && in_ready;
	assign is_cell   = in_data.action == mgd_pkg::ACT_CELL;
	assign rows_open = row_q < eff_h_q;
	assign active    = in_acc && (is_cell ? rows_open : !rows_open);
	assign res_acc   = active && (!is_cell || row_q != '0);
	assign col_next  = {1'b0, col_q} + WW'(1);
	assign last      = col_next == eff_w_q;
	assign out_pop   = out_valid && out_ready;

	// raster counters; the output position is one row behind at the same column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (geom_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (active) begin
			if (!last) begin
				col_q <= col_next[CW-1:0];
			end else if (is_cell) begin
				col_q <= '0;
				row_q <= row_q + HW'(1);
			end else begin
				col_q <= '0;
				row_q <= '0;
			end
		end
	end

	// results owed: accepted but not yet taken at the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({res_acc, out_pop})
				2'b10:   credit_q <= credit_q + CRW'(1);
				2'b01:   credit_q <= credit_q - CRW'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

	// buffer access: write the cell, read down at the same slot and right in the
	// output row; at the end of a row fetch column zero of the next output row
	assign we          = active && is_cell;
	assign waddr       = {row_q[0], col_q};
	assign wcell.cls   = in_data.cell_class;
	assign wcell.val   = in_data.cell_value;
	assign raddr_a     = last ? {row_q[0], CW'(0)} : {~row_q[0], col_next[CW-1:0]};
	assign fwd_a       = we && last && col_q == '0;

	mgd_line_buf #(
		.AW (AW)
	) u_line_buf (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wcell),
		.re      (active),
		.raddr_a (raddr_a),
		.fwd_a   (fwd_a),
		.raddr_b (waddr),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// control that lines up with the buffer read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid     <= active;
			ctl_s1.res       <= res_acc;
			ctl_s1.has_left  <= col_q != '0;
			ctl_s1.has_right <= !last;
			ctl_s1.has_down  <= row_q >= HW'(2);
			ctl_s1.has_up    <= is_cell;
			ctl_s1.last_cell <= !is_cell && last;
			ctl_s1.up        <= wcell;
		end
	end

	mgd_stencil #(
		.FRAC_BITS (FRAC_BITS)
	) u_stencil (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef_x    (coef_x_q),
		.coef_y    (coef_y_q),
		.ctl_s1    (ctl_s1),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.push      (push),
		.push_data (push_data)
	);

	mgd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// a result entering the queue or offered at the port was counted when accepted
	a_push_credited: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> credit_q != '0)
		else $error("result pushed with no credit outstanding");

	a_out_credited: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> credit_q != '0)
		else $error("result offered with no credit outstanding");

	// geometry writes restart the grid
	a_geom_restart: assert property (@(posedge clk) disable iff (!arst_n)
		geom_wr |=> (col_q == '0 && row_q == '0))
		else $error("counters not cleared after geometry write");

	// column counter stays inside the configured width; row counter never passes the height
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < eff_w_q)
		else $error("column counter beyond grid width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= eff_h_q)
		else $error("row counter beyond grid height");

endmodule

### rtl/mgd_line_buf.sv
// two-row line buffer: one write port, two registered read ports
module mgd_line_buf #(
	parameter int AW = 11
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  mgd_pkg::cell_t     wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr_a,
	input  logic               fwd_a,
	input  logic [AW-1:0]      raddr_b,
	output mgd_pkg::cell_t     rdata_a,
	output mgd_pkg::cell_t     rdata_b
);

	mgd_pkg::cell_t mem [2**AW];

	// read-first: port b sees the old entry when it hits the write address,
	// port a can take the write data instead when asked to
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= fwd_a ? wdata : mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### rtl/mgd_stencil.sv
// stencil window and arithmetic pipeline: differences, products, rounding, saturation
module mgd_stencil #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          coef_x,
	input  logic [15:0]          coef_y,
	input  mgd_pkg::stage_ctl_t  ctl_s1,
	input  mgd_pkg::cell_t       rd_a,
	input  mgd_pkg::cell_t       rd_b,
	output logic                 push,
	output mgd_pkg::out_item_t   push_data
);

	localparam int DW = 34;                   // second difference
	localparam int PW = DW + 17;              // coefficient product
	localparam int SW = PW + 1;               // sum of both products
	localparam int QW = SW - FRAC_BITS;       // rounded correction
	localparam int RW = ((QW > 32) ? QW : 32) + 1;
	localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

	// window over the output row: left and center, right comes from the buffer
	mgd_pkg::cell_t win_l_q, win_c_q;

	logic signed [32:0] cx, lx, rx, dx, ux;
	logic signed [32:0] dl, dr, dd, du;
	logic signed [DW-1:0] dxx, dyy;

	logic                 v_s2, last_s2, pass_s2;
	logic signed [31:0]   cval_s2;
	logic signed [DW-1:0] dxx_s2, dyy_s2;

	logic                 v_s3, last_s3, pass_s3;
	logic signed [31:0]   cval_s3;
	logic signed [PW-1:0] px_s3, py_s3;

	logic                 v_s4, last_s4, pass_s4;
	logic signed [31:0]   cval_s4;
	logic signed [SW-1:0] sum_s4;

	logic signed [QW-1:0] q;
	logic signed [RW-1:0] r;
	logic [RW-32:0]       r_hi;
	logic signed [31:0]   sat;

	// window shift on every item that moves the counters
	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			win_l_q <= win_c_q;
			win_c_q <= rd_a;
		end
	end

	// neighbor differences, masked by position and class
	always_comb begin
		cx = {win_c_q.val[31], win_c_q.val};
		lx = {win_l_q.val[31], win_l_q.val};
		rx = {rd_a.val[31], rd_a.val};
		dx = {rd_b.val[31], rd_b.val};
		ux = {ctl_s1.up.val[31], ctl_s1.up.val};
		dl = (ctl_s1.has_left && win_l_q.cls == mgd_pkg::CLS_FLUID) ? cx - lx : '0;
		dr = (ctl_s1.has_right && rd_a.cls == mgd_pkg::CLS_FLUID) ? rx - cx : '0;
		dd = (ctl_s1.has_down && rd_b.cls == mgd_pkg::CLS_FLUID) ? cx - dx : '0;
		du = (ctl_s1.has_up && ctl_s1.up.cls == mgd_pkg::CLS_FLUID) ? ux - cx : '0;
		dxx = {dr[32], dr} - {dl[32], dl};
		dyy = {du[32], du} - {dd[32], dd};
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= ctl_s1.valid && ctl_s1.res;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		last_s2 <= ctl_s1.last_cell;
		pass_s2 <= win_c_q.cls != mgd_pkg::CLS_FLUID;
		cval_s2 <= win_c_q.val;
		dxx_s2  <= dxx;
		dyy_s2  <= dyy;

		last_s3 <= last_s2;
		pass_s3 <= pass_s2;
		cval_s3 <= cval_s2;
		px_s3   <= $signed({1'b0, coef_x}) * dxx_s2;
		py_s3   <= $signed({1'b0, coef_y}) * dyy_s2;

		last_s4 <= last_s3;
		pass_s4 <= pass_s3;
		cval_s4 <= cval_s3;
		sum_s4  <= {px_s3[PW-1], px_s3} + {py_s3[PW-1], py_s3} + HALF;
	end

	// drop fraction bits, add to center, clip to 32 bits
	always_comb begin
		q    = sum_s4[SW-1:FRAC_BITS];
		r    = RW'(q) + RW'(cval_s4);
		r_hi = r[RW-1:31];
		if ((&r_hi) || !(|r_hi)) begin
			sat = r[31:0];
		end else if (r[RW-1]) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = 32'sh7FFF_FFFF;
		end
	end

	assign push                = v_s4;
	assign push_data.new_value = pass_s4 ? cval_s4 : sat;
	assign push_data.last_cell = last_s4;

endmodule

### rtl/mgd_out_fifo.sv
// result queue between the arithmetic pipeline and the output channel
module mgd_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mgd_pkg::out_item_t  push_data,
	input  logic                pop_ready,
	output logic                out_valid,
	output mgd_pkg::out_item_t  out_data
);

	localparam int PTW = $clog2(mgd_pkg::FIFO_DEPTH);
	localparam int LVW = $clog2(mgd_pkg::FIFO_DEPTH + 1);

	mgd_pkg::out_item_t slot_q [mgd_pkg::FIFO_DEPTH];
	logic [PTW-1:0] wr_ptr_q, rd_ptr_q;
	logic [LVW-1:0] level_q;
	logic           pop;

	assign out_valid = level_q != '0;
	assign out_data  = slot_q[rd_ptr_q];
	assign pop       = out_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTW'(1);
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + LVW'(1);
				2'b01:   level_q <= level_q - LVW'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule
